// ----- sv/lfu_pkg.sv -----
// Shared constants and types for the LFU replacement policy unit.
// No dependencies; imported by the policy unit and its testbench.
package lfu_pkg;

   localparam int CAP_BITS        = 5;
   localparam int VICTIM_KEY_BITS = 16;
   localparam int STAMP_BITS      = 32;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   typedef logic [STAMP_BITS-1:0]      stamp_type;
   typedef logic [VICTIM_KEY_BITS-1:0] victim_key_type;
   typedef logic [CAP_BITS-1:0]        cap_type;

endpackage

// ----- sv/lfu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/lfu_replacement_policy_unit.sv -----
// LFU replacement policy unit with oldest-first tie break; uses lfu_pkg and lfu_ram.
// Requests are taken only while idle and stall until the result is issued, since the scan is
// a single pass over the entry RAM (one read per cycle) with one shared compare.
// With capacity zero the scan is skipped and the result is issued from the finish state.
// Reset (synchronous): valid bits cleared, access sequence zero, capacity 16.
// Entry RAM contents are not cleared; entry data is only used while its valid bit is set.
module lfu_replacement_policy_unit #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [KEY_BITS-1:0]            req_access_key,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_was_hit,
   output logic                           rsp_did_evict,
   output lfu_pkg::victim_key_type        rsp_victim_key,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  lfu_pkg::cap_type               csr_write_data
);

   import lfu_pkg::*;

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;
   localparam int WORD_W = KEY_BITS + COUNT_BITS + STAMP_BITS;
   localparam logic [CMP_W-1:0] ENTRIES_CMP = CMP_W'(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   cap_type                cap_ff, cap_in;
   stamp_type              seq_ff, seq_in;
   stamp_type              now_ff, now_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic                   skip_ff, skip_in;
   logic [ENTRIES-1:0]     valid_ff, valid_in;

   logic [OCC_W-1:0]       issue_cnt_ff, issue_cnt_in;
   logic                   chk_pend_ff, chk_pend_in;
   logic [IDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;

   logic                   hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic [COUNT_BITS-1:0]  hit_count_ff, hit_count_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic                   vic_found_ff, vic_found_in;
   logic [IDX_W-1:0]       vic_idx_ff, vic_idx_in;
   logic [COUNT_BITS-1:0]  vic_count_ff, vic_count_in;
   stamp_type              vic_age_ff, vic_age_in;
   logic [KEY_BITS-1:0]    vic_key_ff, vic_key_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic                   rsp_evict_ff, rsp_evict_in;
   victim_key_type         rsp_vkey_ff, rsp_vkey_in;

   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_wr_addr;
   logic [WORD_W-1:0]      ram_wr_data;
   logic [IDX_W-1:0]       ram_rd_addr;
   logic [WORD_W-1:0]      ram_rd_data;

   logic [KEY_BITS-1:0]    e_key;
   logic [COUNT_BITS-1:0]  e_count;
   stamp_type              e_stamp;
   stamp_type              e_age;
   logic                   e_valid;
   logic [COUNT_BITS-1:0]  count_inc;
   logic [CMP_W-1:0]       cap_ext;
   logic [CMP_W-1:0]       cap_eff;
   logic [CMP_W-1:0]       occ_ext;
   logic                   need_evict;
   logic [KEY_BITS+VICTIM_KEY_BITS-1:0] vkey_wide;

   lfu_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign e_key   = ram_rd_data[WORD_W-1 -: KEY_BITS];
   assign e_count = ram_rd_data[STAMP_BITS +: COUNT_BITS];
   assign e_stamp = ram_rd_data[STAMP_BITS-1:0];
   assign e_age   = seq_ff - e_stamp;
   assign e_valid = valid_ff[chk_idx_ff];

   assign count_inc = (&hit_count_ff) ? hit_count_ff : hit_count_ff + 1'b1;
   assign cap_ext   = CMP_W'(cap_ff);
   assign cap_eff   = (cap_ext > ENTRIES_CMP) ? ENTRIES_CMP : cap_ext;
   assign occ_ext   = CMP_W'(occ_ff);
   assign need_evict = (occ_ext >= cap_eff) || !free_found_ff;
   assign vkey_wide  = {{VICTIM_KEY_BITS{1'b0}}, vic_key_ff};

   assign req_stall      = (state_ff != ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_was_hit    = rsp_hit_ff;
   assign rsp_did_evict  = rsp_evict_ff;
   assign rsp_victim_key = rsp_vkey_ff;

   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      seq_in        = seq_ff;
      now_in        = now_ff;
      key_in        = key_ff;
      skip_in       = skip_ff;
      valid_in      = valid_ff;
      issue_cnt_in  = issue_cnt_ff;
      chk_pend_in   = 1'b0;
      chk_idx_in    = chk_idx_ff;
      occ_in        = occ_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_count_in  = hit_count_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      vic_found_in  = vic_found_ff;
      vic_idx_in    = vic_idx_ff;
      vic_count_in  = vic_count_ff;
      vic_age_in    = vic_age_ff;
      vic_key_in    = vic_key_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_hit_in    = rsp_hit_ff;
      rsp_evict_in  = rsp_evict_ff;
      rsp_vkey_in   = rsp_vkey_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = hit_idx_ff;
      ram_wr_data   = {key_ff, COUNT_BITS'(1), now_ff};
      ram_rd_addr   = issue_cnt_ff[IDX_W-1:0];

      if (csr_valid) begin
         cap_in = csr_write_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in        = req_access_key;
               now_in        = seq_ff;
               skip_in       = (cap_ff == '0);
               issue_cnt_in  = '0;
               occ_in        = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               vic_found_in  = 1'b0;
               if (cap_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  seq_in   = seq_ff + 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue one read per cycle; data for chk_idx arrives in the following cycle
            if (issue_cnt_ff < OCC_W'(ENTRIES)) begin
               issue_cnt_in = issue_cnt_ff + 1'b1;
               chk_pend_in  = 1'b1;
               chk_idx_in   = issue_cnt_ff[IDX_W-1:0];
            end
            if (chk_pend_ff) begin
               if (e_valid) begin
                  occ_in = occ_ff + 1'b1;
                  if (!hit_found_ff && e_key == key_ff) begin
                     hit_found_in = 1'b1;
                     hit_idx_in   = chk_idx_ff;
                     hit_count_in = e_count;
                  end
                  // lowest count wins, then the larger age; ties keep the lower slot
                  if (!vic_found_ff || e_count < vic_count_ff ||
                      (e_count == vic_count_ff && e_age > vic_age_ff)) begin
                     vic_found_in = 1'b1;
                     vic_idx_in   = chk_idx_ff;
                     vic_count_in = e_count;
                     vic_age_in   = e_age;
                     vic_key_in   = e_key;
                  end
               end else if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = chk_idx_ff;
               end
               if (chk_idx_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               rsp_evict_in = 1'b0;
               rsp_vkey_in  = '0;
               state_in     = ST_IDLE;
               if (!skip_ff) begin
                  if (hit_found_ff) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = hit_idx_ff;
                     ram_wr_data = {key_ff, count_inc, now_ff};
                     rsp_hit_in  = 1'b1;
                  end else if (need_evict) begin
                     if (vic_found_ff) begin
                        ram_wr_en    = 1'b1;
                        ram_wr_addr  = vic_idx_ff;
                        rsp_evict_in = 1'b1;
                        rsp_vkey_in  = vkey_wide[VICTIM_KEY_BITS-1:0];
                     end
                  end else begin
                     ram_wr_en             = 1'b1;
                     ram_wr_addr           = free_idx_ff;
                     valid_in[free_idx_ff] = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         seq_ff       <= '0;
         valid_ff     <= '0;
         chk_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         seq_ff       <= seq_in;
         valid_ff     <= valid_in;
         chk_pend_ff  <= chk_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff        <= now_in;
      key_ff        <= key_in;
      skip_ff       <= skip_in;
      issue_cnt_ff  <= issue_cnt_in;
      chk_idx_ff    <= chk_idx_in;
      occ_ff        <= occ_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_count_ff  <= hit_count_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      vic_found_ff  <= vic_found_in;
      vic_idx_ff    <= vic_idx_in;
      vic_count_ff  <= vic_count_in;
      vic_age_ff    <= vic_age_in;
      vic_key_ff    <= vic_key_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_evict_ff  <= rsp_evict_in;
      rsp_vkey_ff   <= rsp_vkey_in;
   end

endmodule

// ----- tb/sv/lfu_replacement_policy_unit_tb.sv -----
// Self-checking testbench for lfu_replacement_policy_unit: directed table, then random accesses.
// Keeps its own LFU table model and checks every result beat; depends on lfu_pkg and the RTL.
module lfu_replacement_policy_unit_tb;
   import lfu_pkg::*;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 16;
   localparam int COUNT_BITS = 16;
   localparam int SETTLE     = ENTRIES + 4;
   localparam int PLAN_ROWS  = 29;
   localparam int PHASES     = 8;
   localparam int POOL_MAX   = 24;
   localparam int FIFO_DEPTH = 4;

   typedef struct packed {
      logic           was_hit;
      logic           did_evict;
      victim_key_type victim_key;
   } access_outcome_type;

   typedef enum logic {ROW_ACCESS, ROW_SET_CAP} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [15:0]        value;
      logic               typed;
      access_outcome_type outcome;
   } plan_row_type;

   localparam access_outcome_type OUTCOME_QUIET = '{1'b0, 1'b0, 16'h0000};
   localparam access_outcome_type OUTCOME_HIT   = '{1'b1, 1'b0, 16'h0000};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [KEY_BITS-1:0] req_access_key = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_was_hit;
   logic                rsp_did_evict;
   victim_key_type      rsp_victim_key;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   cap_type             csr_write_data = '0;

   lfu_replacement_policy_unit #(
      .ENTRIES   (ENTRIES),
      .KEY_BITS  (KEY_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_access_key(req_access_key),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_was_hit   (rsp_was_hit),
      .rsp_did_evict (rsp_did_evict),
      .rsp_victim_key(rsp_victim_key),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_write_data(csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // LFU table mirror
   logic                  slot_live [ENTRIES];
   logic [KEY_BITS-1:0]   slot_tag  [ENTRIES];
   logic [COUNT_BITS-1:0] slot_uses [ENTRIES];
   stamp_type             slot_when [ENTRIES];
   stamp_type             access_seq;
   cap_type               cache_cap;

   // expected result beats, in order of acceptance
   access_outcome_type outcome_fifo [FIFO_DEPTH];
   int fifo_wr_ptr    = 0;
   int fifo_rd_ptr    = 0;
   int mismatches     = 0;
   int accesses_sent  = 0;
   int hits_seen      = 0;
   int evictions_seen = 0;
   int cap_writes     = 0;
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   bit req_driven     = 0;

   function automatic access_outcome_type predict_lfu_access(input logic [KEY_BITS-1:0] key);
      access_outcome_type result;
      int                 eff_cap;
      int                 occupied;
      int                 free_idx;
      int                 hit_idx;
      int                 victim;
      stamp_type          now;
      stamp_type          age;
      stamp_type          best_age;
      result = OUTCOME_QUIET;
      if (cache_cap == 0)
         return result;
      eff_cap = (int'(cache_cap) > ENTRIES) ? ENTRIES : int'(cache_cap);
      now = access_seq;
      access_seq = now + 1;
      occupied = 0;
      free_idx = -1;
      hit_idx = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_live[i]) begin
            occupied++;
            if (hit_idx < 0 && slot_tag[i] == key)
               hit_idx = i;
         end else if (free_idx < 0) begin
            free_idx = i;
         end
      end
      if (hit_idx >= 0) begin
         if (slot_uses[hit_idx] != '1)
            slot_uses[hit_idx] = slot_uses[hit_idx] + 1'b1;
         slot_when[hit_idx] = now;
         result.was_hit = 1'b1;
         return result;
      end
      if (occupied >= eff_cap || free_idx < 0) begin
         // lowest count wins, then the largest age (wrap-safe difference)
         victim = -1;
         best_age = '0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_live[i])
               continue;
            age = access_seq - slot_when[i];
            if (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                  (slot_uses[i] == slot_uses[victim] && age > best_age)) begin
               victim = i;
               best_age = age;
            end
         end
         if (victim < 0)
            return result;
         result.did_evict = 1'b1;
         result.victim_key = victim_key_type'(slot_tag[victim]);
         free_idx = victim;
      end
      slot_live[free_idx] = 1'b1;
      slot_tag[free_idx]  = key;
      slot_uses[free_idx] = COUNT_BITS'(1);
      slot_when[free_idx] = now;
      return result;
   endfunction

   task automatic send_access(input logic [KEY_BITS-1:0] key, input logic use_typed,
                              input access_outcome_type typed_outcome);
      access_outcome_type predicted;
      req_valid <= 1'b1;
      req_access_key <= key;
      req_driven = 1;
      do @(posedge clock); while (req_stall);
      predicted = predict_lfu_access(key);
      outcome_fifo[fifo_wr_ptr % FIFO_DEPTH] = use_typed ? typed_outcome : predicted;
      fifo_wr_ptr++;
      accesses_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_driven = 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic wait_for_results(input int settle_cycles);
      if (req_driven) begin
         req_valid <= 1'b0;
         req_driven = 0;
         @(posedge clock);
      end
      while (fifo_wr_ptr != fifo_rd_ptr)
         @(posedge clock);
      repeat (settle_cycles) @(posedge clock);
   endtask

   task automatic write_capacity(input cap_type value);
      csr_valid <= 1'b1;
      csr_write_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cache_cap = value;
      cap_writes++;
      @(posedge clock);
   endtask

   // receiver side: random stall, result beats checked in order
   always @(posedge clock) begin
      access_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (fifo_wr_ptr == fifo_rd_ptr) begin
            $error("result beat with no expectation pending");
            mismatches++;
         end else begin
            want = outcome_fifo[fifo_rd_ptr % FIFO_DEPTH];
            fifo_rd_ptr++;
            if (rsp_was_hit !== want.was_hit) begin
               $error("was_hit: expected %0d, got %0d", want.was_hit, rsp_was_hit);
               mismatches++;
            end
            if (rsp_did_evict !== want.did_evict) begin
               $error("did_evict: expected %0d, got %0d", want.did_evict, rsp_did_evict);
               mismatches++;
            end
            if (rsp_victim_key !== want.victim_key) begin
               $error("victim_key: expected %h, got %h", want.victim_key, rsp_victim_key);
               mismatches++;
            end
            hits_seen += want.was_hit;
            evictions_seen += want.did_evict;
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   initial begin
      plan_row_type        plan [PLAN_ROWS];
      int                  phase_cap   [PHASES];
      int                  phase_items [PHASES];
      int                  phase_send  [PHASES];
      int                  phase_stall [PHASES];
      logic [KEY_BITS-1:0] key_pool [POOL_MAX];
      int                  pool_size;
      logic [KEY_BITS-1:0] key;

      for (int i = 0; i < ENTRIES; i++) begin
         slot_live[i] = 1'b0;
         slot_tag[i]  = '0;
         slot_uses[i] = '0;
         slot_when[i] = '0;
      end
      access_seq = '0;
      cache_cap = CAP_RESET;

      // reset capacity 16: fill, hit, shrink, disable, overfill, shrink below occupancy
      plan = '{
         '{ROW_ACCESS,  16'h0000, 1'b1, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'hFFFF, 1'b1, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h0000, 1'b1, OUTCOME_HIT},
         '{ROW_SET_CAP, 16'd2,    1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h1234, 1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'hAAAA, 1'b0, OUTCOME_QUIET},
         '{ROW_SET_CAP, 16'd0,    1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h5555, 1'b1, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h0000, 1'b1, OUTCOME_QUIET},
         '{ROW_SET_CAP, 16'd31,   1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h0001, 1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h0002, 1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h0004, 1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h0008, 1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h0010, 1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h0020, 1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h0040, 1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h0080, 1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h0100, 1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h0200, 1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h0400, 1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h0800, 1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h1000, 1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h2000, 1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h4000, 1'b0, OUTCOME_QUIET},
         '{ROW_SET_CAP, 16'd1,    1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h0000, 1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h7FFF, 1'b0, OUTCOME_QUIET},
         '{ROW_ACCESS,  16'h8000, 1'b0, OUTCOME_QUIET}
      };
      // capacity -1 means a random nonzero setting
      phase_cap   = '{16,  1, 17,  4,  0,  9,  2, -1};
      phase_items = '{60, 40, 60, 60, 10, 60, 50, 60};
      phase_send  = '{ 0, 51,  0, 10,  0, 51, 10,  0};
      phase_stall = '{ 0,  0, 51, 10,  0,  0, 10, 51};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[r]) begin
         if (plan[r].kind == ROW_SET_CAP) begin
            wait_for_results(SETTLE);
            write_capacity(cap_type'(plan[r].value));
         end else begin
            send_access(plan[r].value[KEY_BITS-1:0], plan[r].typed, plan[r].outcome);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_for_results(SETTLE);
         send_idle_pct = phase_send[p];
         stall_pct = phase_stall[p];
         write_capacity(phase_cap[p] < 0 ? cap_type'($urandom_range(31, 1))
                                         : cap_type'(phase_cap[p]));
         // a small working set keeps hits and count ties frequent
         pool_size = $urandom_range(POOL_MAX, 2);
         for (int k = 0; k < POOL_MAX; k++)
            key_pool[k] = KEY_BITS'($urandom_range(16'hFFFF));
         for (int n = 0; n < phase_items[p]; n++) begin
            if ((p == 1 && n == 20) || $urandom_range(39) == 0)
               wait_for_results(0);
            if ($urandom_range(9) == 0)
               key = KEY_BITS'($urandom_range(16'hFFFF));
            else
               key = key_pool[$urandom_range(pool_size - 1)];
            send_access(key, 1'b0, OUTCOME_QUIET);
         end
      end

      wait_for_results(SETTLE);
      $display("Checked %0d accesses across %0d capacity settings.", accesses_sent, cap_writes);
      $display("Hits seen: %0d, evictions seen: %0d.", hits_seen, evictions_seen);
      if (mismatches == 0 && fifo_wr_ptr == fifo_rd_ptr)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/lfu_pkg.sv
sv/lfu_ram.sv
sv/lfu_replacement_policy_unit.sv
tb/sv/lfu_replacement_policy_unit_tb.sv
